>>> src/csg_pkg.sv
// Package for the CSG span table combiner: widths, codes and shared types.
// No dependencies.
package csg_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int OBJ_ID_BITS = 16;
    localparam int DIST_BITS = 32;
    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_COMBINE = 2'd2;
    localparam logic [1:0] FUNC_NEAREST = 2'd3;

    localparam logic [1:0] MODE_ISECT = 2'd0;
    localparam logic [1:0] MODE_DIFF = 2'd1;
    localparam logic [1:0] MODE_KEEP = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef struct packed {
        logic signed [DIST_BITS-1:0] t_in;
        logic [OBJ_ID_BITS-1:0] o_in;
        logic signed [DIST_BITS-1:0] t_out;
        logic [OBJ_ID_BITS-1:0] o_out;
    } span_t;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] mode;
        span_t span;
    } req_t;

    typedef struct packed {
        logic status;
        logic found;
        logic signed [DIST_BITS-1:0] nearest_t;
        logic [OBJ_ID_BITS-1:0] nearest_obj;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic append;
        logic rd;
        logic [IDX_BITS-1:0] rd_idx;
        logic proc;
        logic [IDX_BITS-1:0] proc_idx;
        logic finish;
    } csg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic [1:0] func;
        logic split;
    } csg_sts_t;
endpackage

>>> src/csg_if.sv
// Valid/ready channel interface carrying a generic payload.
// No dependencies; the payload type is a parameter.
interface csg_if #(parameter type payload_t = logic) (input logic clk);
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/csg_ctrl.sv
// Controller for the CSG span combiner: sequences the table walk.
// Depends on csg_pkg.
module csg_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  csg_pkg::csg_sts_t sts,
    output csg_pkg::csg_cmd_t cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [csg_pkg::CNT_BITS-1:0] idx_reg, idx_next;
    logic [csg_pkg::CNT_BITS-1:0] limit_reg, limit_next;
    logic pend_reg, pend_next;
    logic [csg_pkg::IDX_BITS-1:0] pidx_reg, pidx_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        limit_next = limit_reg;
        pend_next = 1'b0;
        pidx_next = pidx_reg;
        cmd = '0;
        cmd.proc = pend_reg;
        cmd.proc_idx = pidx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    limit_next = sts.count;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.func == csg_pkg::FUNC_CLEAR)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.func == csg_pkg::FUNC_APPEND)
                begin
                    cmd.append = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.split)
                    // hold the walk so that no entry update competes with the split remainder write
                    idx_next = idx_reg;
                else if (idx_reg < limit_reg)
                begin
                    cmd.rd = 1'b1;
                    cmd.rd_idx = idx_reg[csg_pkg::IDX_BITS-1:0];
                    pend_next = 1'b1;
                    pidx_next = idx_reg[csg_pkg::IDX_BITS-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!pend_reg)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            limit_reg <= '0;
            pend_reg <= 1'b0;
            pidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            limit_reg <= limit_next;
            pend_reg <= pend_next;
            pidx_reg <= pidx_next;
        end
    end
endmodule

>>> src/csg_dp.sv
// Datapath for the CSG span combiner: span memory, live bits, span logic.
// Depends on csg_pkg.
module csg_dp
(
    input  logic clk,
    input  logic rst_n,
    input  csg_pkg::req_t req,
    input  csg_pkg::csg_cmd_t cmd,
    output csg_pkg::csg_sts_t sts,
    output csg_pkg::rsp_t rsp
);
    csg_pkg::span_t mem [csg_pkg::TABLE_DEPTH];
    csg_pkg::span_t rd_reg;
    logic [csg_pkg::TABLE_DEPTH-1:0] live_reg, live_next;
    logic [csg_pkg::CNT_BITS-1:0] count_reg, count_next;
    csg_pkg::req_t req_reg;
    logic status_reg, status_next;
    logic have_reg, have_next;
    logic signed [csg_pkg::DIST_BITS-1:0] best_t_reg, best_t_next;
    logic [csg_pkg::OBJ_ID_BITS-1:0] best_o_reg, best_o_next;
    csg_pkg::rsp_t rsp_reg;

    csg_pkg::span_t a, b, a_new, wr_span;
    logic wr_en;
    logic [csg_pkg::IDX_BITS-1:0] wr_idx;
    logic full;
    logic split_now;
    logic signed [csg_pkg::DIST_BITS-1:0] ht;
    logic [csg_pkg::OBJ_ID_BITS-1:0] ho;
    logic hv;

    assign sts.count = count_reg;
    assign sts.func = req_reg.func;
    assign sts.split = split_now;
    assign rsp = rsp_reg;
    assign full = (count_reg >= csg_pkg::CNT_BITS'(csg_pkg::TABLE_DEPTH));

    always_comb
    begin
        a = rd_reg;
        b = req_reg.span;
        a_new = a;
        live_next = live_reg;
        count_next = count_reg;
        status_next = status_reg;
        have_next = have_reg;
        best_t_next = best_t_reg;
        best_o_next = best_o_reg;
        wr_en = 1'b0;
        wr_idx = cmd.proc_idx;
        wr_span = a;
        split_now = 1'b0;
        ht = best_t_reg;
        ho = best_o_reg;
        hv = have_reg;
        if (cmd.load)
        begin
            status_next = 1'b0;
            have_next = 1'b0;
            best_t_next = '0;
            best_o_next = '0;
        end
        if (cmd.clear)
        begin
            live_next = '0;
            count_next = '0;
        end
        if (cmd.append)
        begin
            if (full)
                status_next = 1'b1;
            else
            begin
                wr_en = 1'b1;
                wr_idx = count_reg[csg_pkg::IDX_BITS-1:0];
                wr_span = b;
                live_next[count_reg[csg_pkg::IDX_BITS-1:0]] = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.proc && live_reg[cmd.proc_idx])
        begin
            if (req_reg.func == csg_pkg::FUNC_NEAREST)
            begin
                if (a.t_in >= 0 && (!hv || a.t_in < ht))
                begin
                    hv = 1'b1;
                    ht = a.t_in;
                    ho = a.o_in;
                end
                if (a.t_out >= 0 && (!hv || a.t_out < ht))
                begin
                    hv = 1'b1;
                    ht = a.t_out;
                    ho = a.o_out;
                end
                have_next = hv;
                best_t_next = ht;
                best_o_next = ho;
            end
            else if (req_reg.mode == csg_pkg::MODE_ISECT)
            begin
                if (a.t_out <= b.t_in || a.t_in >= b.t_out)
                    live_next[cmd.proc_idx] = 1'b0;
                else if (b.t_in <= a.t_in && b.t_out >= a.t_out)
                    a_new = a;
                else if (a.t_in <= b.t_in && a.t_out >= b.t_out)
                    a_new = b;
                else if (a.t_in <= b.t_in && a.t_out <= b.t_out)
                begin
                    a_new.t_in = b.t_in;
                    a_new.o_in = b.o_in;
                end
                else if (b.t_in <= a.t_in && b.t_out <= a.t_out)
                begin
                    a_new.t_out = b.t_out;
                    a_new.o_out = b.o_out;
                end
                wr_en = 1'b1;
                wr_span = a_new;
            end
            else if (req_reg.mode == csg_pkg::MODE_DIFF)
            begin
                if (a.t_in >= b.t_in && a.t_out <= b.t_out)
                    live_next[cmd.proc_idx] = 1'b0;
                else if (b.t_in >= a.t_out || b.t_out <= a.t_in)
                    a_new = a;
                else if (a.t_in < b.t_in && a.t_out > b.t_out)
                begin
                    a_new.t_out = b.t_in;
                    a_new.o_out = b.o_in;
                    if (full)
                        status_next = 1'b1;
                    else
                    begin
                        split_now = 1'b1;
                        live_next[count_reg[csg_pkg::IDX_BITS-1:0]] = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (b.t_in > a.t_in && b.t_out > a.t_out)
                begin
                    a_new.t_out = b.t_in;
                    a_new.o_out = b.o_in;
                end
                else if (a.t_in > b.t_in && b.t_out < a.t_out)
                begin
                    a_new.t_in = b.t_out;
                    a_new.o_in = b.o_out;
                end
                wr_en = 1'b1;
                wr_span = a_new;
            end
        end
    end

    // split remainder registered, written in the cycle after the split while no entry update uses the port
    logic split_reg;
    logic [csg_pkg::IDX_BITS-1:0] split_idx_reg;
    csg_pkg::span_t split_span_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_span;
        else if (split_reg)
            mem[split_idx_reg] <= split_span_reg;
        if (cmd.rd)
            rd_reg <= mem[cmd.rd_idx];
        if (cmd.load)
            req_reg <= req;
        split_span_reg.t_in <= b.t_out;
        split_span_reg.o_in <= b.o_out;
        split_span_reg.t_out <= a.t_out;
        split_span_reg.o_out <= a.o_out;
        split_idx_reg <= count_reg[csg_pkg::IDX_BITS-1:0];
        best_t_reg <= best_t_next;
        best_o_reg <= best_o_next;
        if (cmd.finish)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.found <= have_reg;
            rsp_reg.nearest_t <= have_reg ? best_t_reg : '0;
            rsp_reg.nearest_obj <= have_reg ? best_o_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            count_reg <= '0;
            status_reg <= 1'b0;
            have_reg <= 1'b0;
            split_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            count_reg <= count_next;
            status_reg <= status_next;
            have_reg <= have_next;
            split_reg <= split_now;
        end
    end
endmodule

>>> src/csg_span_table_combiner_top.sv
// Top level of the CSG span table combiner: controller plus datapath.
// Depends on csg_pkg, csg_if, csg_ctrl and csg_dp.
//
// Usage: one request channel (func, mode, operand span) and one response
// channel (status, found, nearest_t, nearest_obj); valid/ready handshakes.
// Every request gives exactly one response, in order.
// Clear and append load the request, do the operation, finish and respond.
// Combine and nearest walk the table one entry per cycle over the single
// memory read port, but the walk holds for each difference split that
// appends a remainder.
// One request is worked on at a time; the next is taken once the response
// transaction has completed. A stalled receiver holds the response and the
// block takes no new request meanwhile.
// Reset clears the live bits and the entry count; span memory is not
// cleared, entries are only read after being written.
// A difference split writes its remainder to the table end the cycle after
// the entry itself is updated; the walk holds in the cycle of the update and
// never reads that slot in the same request.
module csg_span_table_combiner_top
(
    input logic clk,
    input logic rst_n,
    csg_if.sink in_ch,
    csg_if.source out_ch
);
    csg_pkg::csg_cmd_t cmd;
    csg_pkg::csg_sts_t sts;
    csg_pkg::rsp_t rsp;

    csg_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .sts(sts),
        .cmd(cmd)
    );

    csg_dp u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .req(in_ch.data),
        .cmd(cmd),
        .sts(sts),
        .rsp(rsp)
    );

    assign out_ch.data = rsp;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= csg_pkg::CNT_BITS'(csg_pkg::TABLE_DEPTH))
        else $error("entry count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("request taken while response pending");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(rsp))
        else $error("response changed while stalled");
endmodule
